@@ rtl/mpva_pkg.sv @@
package mpva_pkg;

    // Voice slots, the slot index width and the count width that follows from them
    localparam int VOICE_COUNT = 3;
    localparam int SLOT_W      = 2;
    localparam int CNT_W       = $clog2(VOICE_COUNT + 1);

    // Result commands
    localparam logic [1:0] CMD_OFF = 2'd0;
    localparam logic [1:0] CMD_ON  = 2'd1;
    localparam logic [1:0] CMD_VOL = 2'd2;

    // Input actions
    localparam logic ACT_BYTE  = 1'b0;
    localparam logic ACT_PANIC = 1'b1;

    // Status nibbles
    localparam logic [3:0] EV_NOTE_OFF = 4'h8;
    localparam logic [3:0] EV_NOTE_ON  = 4'h9;
    localparam logic [3:0] EV_KEY_PRES = 4'hA;
    localparam logic [3:0] EV_CTRL     = 4'hB;
    localparam logic [3:0] EV_PROG     = 4'hC;
    localparam logic [3:0] EV_CH_PRES  = 4'hD;
    localparam logic [3:0] EV_BEND     = 4'hE;

    // System common bytes
    localparam logic [7:0] SYS_EX_START  = 8'hF0;
    localparam logic [7:0] SYS_TIME_CODE = 8'hF1;
    localparam logic [7:0] SYS_SONG_POS  = 8'hF2;
    localparam logic [7:0] SYS_SONG_SEL  = 8'hF3;
    localparam logic [7:0] SYS_EX_END    = 8'hF7;

    // Top five bits of a real-time byte
    localparam logic [4:0] REALTIME_TOP = 5'b11111;

    // Controller numbers that silence all voices
    localparam logic [7:0] CC_ALL_SOUND_OFF = 8'd120;
    localparam logic [7:0] CC_MODE_LO       = 8'd122;
    localparam logic [7:0] CC_MODE_HI       = 8'd127;

    // Note number that marks a free slot
    localparam logic [7:0] NOTE_NONE = 8'd128;

    // Framing counter
    localparam logic [3:0] IDX_MAX  = 4'd15;
    localparam logic [3:0] MSG_KEEP = 4'd3;

    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        logic [1:0]        command;
        logic [3:0]        midi_channel;
        logic [7:0]        note;
    } t_result;

    typedef struct packed {
        logic       valid;
        logic [7:0] status;
        logic [7:0] data1;
        logic [7:0] data2;
    } t_msg;

    typedef struct packed {
        logic       busy;
        logic [3:0] ch;
        logic [7:0] note;
    } t_voice;

endpackage

@@ rtl/mpva_parser.sv @@
module mpva_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  logic              i_action,
    input  logic [7:0]        i_byte,
    output mpva_pkg::t_msg    o_msg
);

    typedef enum logic [3:0] {
        PS_IDLE  = 4'b0001,
        PS_TWO   = 4'b0010,
        PS_SYSEX = 4'b0100,
        PS_LAST  = 4'b1000
    } t_pstate;

    typedef struct packed {
        t_pstate st;
        logic    dec;
    } t_step;

    t_pstate    r_ps, n_ps;
    logic [7:0] r_rs, n_rs;
    logic [3:0] r_idx, n_idx;
    logic [7:0] r_msg [3];
    logic [7:0] n_msg [3];
    t_pstate    st;
    t_step      step;

    // Advance the framing by one byte
    function automatic t_step advance(input t_pstate cur, input logic [7:0] b);
        t_step      res;
        logic [3:0] ev;
        ev      = b[7:4];
        res.st  = PS_IDLE;
        res.dec = 1'b0;
        case (cur)
            PS_IDLE: begin
                if (ev inside {mpva_pkg::EV_NOTE_OFF, mpva_pkg::EV_NOTE_ON,
                               mpva_pkg::EV_KEY_PRES, mpva_pkg::EV_CTRL,
                               mpva_pkg::EV_BEND}
                    || b == mpva_pkg::SYS_SONG_POS) begin
                    res.st = PS_TWO;
                end else if (ev inside {mpva_pkg::EV_PROG, mpva_pkg::EV_CH_PRES}
                             || b == mpva_pkg::SYS_TIME_CODE
                             || b == mpva_pkg::SYS_SONG_SEL) begin
                    res.st = PS_LAST;
                end else if (b == mpva_pkg::SYS_EX_START) begin
                    res.st = PS_SYSEX;
                end
            end
            PS_TWO:   res.st = PS_LAST;
            PS_SYSEX: begin
                if (b == mpva_pkg::SYS_EX_END) begin
                    res.dec = 1'b1;
                end else begin
                    res.st = PS_SYSEX;
                end
            end
            PS_LAST:  res.dec = 1'b1;
            default:  res.st = PS_IDLE;
        endcase
        return res;
    endfunction

    // Frame the byte with running status and keep the first three bytes
    always_comb begin
        n_ps     = r_ps;
        n_rs     = r_rs;
        n_idx    = r_idx;
        n_msg    = r_msg;
        st       = r_ps;
        step.st  = r_ps;
        step.dec = 1'b0;
        if (i_fire) begin
            if (i_action == mpva_pkg::ACT_PANIC) begin
                n_ps = PS_IDLE;
                n_rs = '0;
            end else if (i_byte[7:3] != mpva_pkg::REALTIME_TOP) begin
                if (r_ps == PS_IDLE) begin
                    n_idx = '0;
                    if (r_rs == '0 || i_byte[7]) begin
                        n_rs = i_byte;
                    end else begin
                        // replay the running status as the first byte
                        n_msg[0] = r_rs;
                        n_idx    = 4'd1;
                        step     = advance(PS_IDLE, r_rs);
                        st       = step.st;
                    end
                end
                if (n_idx < mpva_pkg::MSG_KEEP) begin
                    n_msg[n_idx[1:0]] = i_byte;
                end
                if (n_idx != mpva_pkg::IDX_MAX) begin
                    n_idx = n_idx + 4'd1;
                end
                step = advance(st, i_byte);
                n_ps = step.st;
            end
        end
    end

    assign o_msg.valid  = step.dec;
    assign o_msg.status = n_msg[0];
    assign o_msg.data1  = n_msg[1];
    assign o_msg.data2  = n_msg[2];

    // Hold the parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ps  <= PS_IDLE;
            r_rs  <= '0;
            r_idx <= '0;
        end else begin
            r_ps  <= n_ps;
            r_rs  <= n_rs;
            r_idx <= n_idx;
        end
    end

    // Message bytes need no reset
    always_ff @(posedge i_clk) begin
        r_msg <= n_msg;
    end

endmodule

@@ rtl/mpva_voices.sv @@
module mpva_voices (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_panic,
    input  mpva_pkg::t_msg                i_msg,
    output mpva_pkg::t_result             o_res [mpva_pkg::VOICE_COUNT],
    output logic [mpva_pkg::CNT_W-1:0]    o_cnt
);

    mpva_pkg::t_voice r_voice [mpva_pkg::VOICE_COUNT];
    mpva_pkg::t_voice n_voice [mpva_pkg::VOICE_COUNT];

    logic [3:0]                  ev;
    logic [3:0]                  ch;
    logic [7:0]                  note;
    logic [7:0]                  vel;
    logic                        all_off;
    logic                        found;
    logic                        match;
    logic [mpva_pkg::SLOT_W-1:0] hit;

    // Decode one message against the slots
    always_comb begin
        n_voice = r_voice;
        o_cnt   = '0;
        for (int i = 0; i < mpva_pkg::VOICE_COUNT; i++) begin
            o_res[i]              = '0;
            o_res[i].slot         = mpva_pkg::SLOT_W'(i);
            o_res[i].command      = mpva_pkg::CMD_OFF;
        end

        ev   = i_msg.status[7:4];
        ch   = i_msg.status[3:0];
        note = i_msg.data1;
        vel  = i_msg.data2;

        all_off = i_panic
                  || (i_msg.valid && ev == mpva_pkg::EV_CTRL
                      && (note inside {mpva_pkg::CC_ALL_SOUND_OFF,
                                       [mpva_pkg::CC_MODE_LO:mpva_pkg::CC_MODE_HI]}));

        // zero velocity turns note-on and key pressure into note-off
        if ((ev == mpva_pkg::EV_NOTE_ON || ev == mpva_pkg::EV_KEY_PRES) && vel == '0) begin
            ev = mpva_pkg::EV_NOTE_OFF;
        end

        // first free slot for note-on, else the slot holding this note
        found = 1'b0;
        hit   = '0;
        match = 1'b0;
        for (int i = mpva_pkg::VOICE_COUNT - 1; i >= 0; i--) begin
            if (ev == mpva_pkg::EV_NOTE_ON) begin
                match = !r_voice[i].busy;
            end else begin
                match = r_voice[i].busy && r_voice[i].ch == ch && r_voice[i].note == note;
            end
            if (match) begin
                found = 1'b1;
                hit   = mpva_pkg::SLOT_W'(i);
            end
        end

        if (all_off) begin
            for (int i = 0; i < mpva_pkg::VOICE_COUNT; i++) begin
                n_voice[i] = '0;
            end
            o_cnt = mpva_pkg::CNT_W'(mpva_pkg::VOICE_COUNT);
        end else if (i_msg.valid && found) begin
            o_res[0].slot = hit;
            case (ev)
                mpva_pkg::EV_NOTE_OFF: begin
                    n_voice[hit] = '0;
                    o_cnt        = mpva_pkg::CNT_W'(1);
                end
                mpva_pkg::EV_KEY_PRES: begin
                    o_res[0].command = mpva_pkg::CMD_VOL;
                    o_cnt            = mpva_pkg::CNT_W'(1);
                end
                mpva_pkg::EV_NOTE_ON: begin
                    o_cnt = mpva_pkg::CNT_W'(1);
                    // the free-note number leaves the slot free
                    if (note != mpva_pkg::NOTE_NONE) begin
                        n_voice[hit].busy     = 1'b1;
                        n_voice[hit].ch       = ch;
                        n_voice[hit].note     = note;
                        o_res[0].command      = mpva_pkg::CMD_ON;
                        o_res[0].midi_channel = ch;
                        o_res[0].note         = note;
                    end
                end
                default: o_cnt = '0;
            endcase
        end
    end

    // Hold the voice slots
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < mpva_pkg::VOICE_COUNT; i++) begin
                r_voice[i] <= '0;
            end
        end else begin
            r_voice <= n_voice;
        end
    end

endmodule

@@ rtl/mpva_out_buf.sv @@
module mpva_out_buf (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [mpva_pkg::CNT_W-1:0]    i_cnt,
    input  mpva_pkg::t_result             i_res [mpva_pkg::VOICE_COUNT],
    input  logic                          i_ready,
    output logic                          o_valid,
    output logic                          o_last,
    output mpva_pkg::t_result             o_res,
    output logic                          o_can_load
);

    logic [mpva_pkg::CNT_W-1:0] r_rem;
    mpva_pkg::t_result          r_ent [mpva_pkg::VOICE_COUNT];
    logic                       take;

    assign o_valid    = r_rem != '0;
    assign o_last     = r_rem == mpva_pkg::CNT_W'(1);
    assign o_res      = r_ent[0];
    assign take       = o_valid && i_ready;
    assign o_can_load = !o_valid || (o_last && i_ready);

    // Count the words left in the group
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
        end else if (i_load) begin
            r_rem <= i_cnt;
        end else if (take) begin
            r_rem <= r_rem - mpva_pkg::CNT_W'(1);
        end
    end

    // Load a group, or shift it down one word per take
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_ent <= i_res;
        end else if (take) begin
            for (int i = 0; i < mpva_pkg::VOICE_COUNT - 1; i++) begin
                r_ent[i] <= r_ent[i+1];
            end
        end
    end

endmodule

@@ rtl/midi_parser_voice_allocator.sv @@
// An accepted word waits in the input register until the output buffer can load its results.
// Throughput: one input word per cycle while the output buffer can load; a word with results
// holds the input until the single result port, draining one word per cycle while i_ready is
// high, reaches the group's last word. Words that cause no result pass at one per cycle.
// Reset (synchronous, active low): parser idle with no running status, all voices free.
module midi_parser_voice_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [1:0]  o_slot,
    output logic [1:0]  o_command,
    output logic [3:0]  o_midi_channel,
    output logic [7:0]  o_note,
    output logic        o_last
);

    logic                       r_in_vld;
    logic                       r_in_action;
    logic [7:0]                 r_in_byte;
    logic                       fire;
    logic                       can_load;
    logic                       panic;
    mpva_pkg::t_msg             msg;
    mpva_pkg::t_result          grp [mpva_pkg::VOICE_COUNT];
    logic [mpva_pkg::CNT_W-1:0] grp_cnt;
    mpva_pkg::t_result          res;

    assign fire    = r_in_vld && can_load;
    assign o_ready = !r_in_vld || fire;
    assign panic   = fire && r_in_action == mpva_pkg::ACT_PANIC;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_action <= i_action;
            r_in_byte   <= i_data_byte;
        end
    end

    mpva_parser u_parser (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (fire),
        .i_action (r_in_action),
        .i_byte   (r_in_byte),
        .o_msg    (msg)
    );

    mpva_voices u_voices (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_panic (panic),
        .i_msg   (msg),
        .o_res   (grp),
        .o_cnt   (grp_cnt)
    );

    mpva_out_buf u_out_buf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (fire),
        .i_cnt      (grp_cnt),
        .i_res      (grp),
        .i_ready    (i_ready),
        .o_valid    (o_valid),
        .o_last     (o_last),
        .o_res      (res),
        .o_can_load (can_load)
    );

    assign o_slot         = res.slot;
    assign o_command      = res.command;
    assign o_midi_channel = res.midi_channel;
    assign o_note         = res.note;

endmodule

@@ verif/tb_midi_parser_voice_allocator.sv @@
`timescale 1ns / 1ps

module tb_midi_parser_voice_allocator;

    localparam int         RANDOM_ITEMS = 132;
    localparam int         DRAIN_EVERY  = 45;
    localparam int         LONG_HOLD    = 300;
    localparam int         IDLE_LIMIT   = 4000;
    localparam int         TAIL_CYCLES  = 20;
    localparam int         HOLD_AT_WORD = 70;
    localparam logic [7:0] FREE_CHAN    = 8'hFF;
    localparam logic [7:0] RT_CLOCK     = 8'hF8;
    localparam logic [7:0] SYS_TUNE_REQ = 8'hF6;

    typedef enum logic [3:0] {
        PS_IDLE      = 4'b0001,
        PS_TWO_DATA  = 4'b0010,
        PS_SYSEX     = 4'b0100,
        PS_LAST_DATA = 4'b1000
    } t_parse_state;

    typedef struct packed {
        logic       action;
        logic [7:0] data;
        logic       hold_for_drain;
    } t_midi_word;

    typedef struct packed {
        logic [1:0] slot;
        logic [1:0] command;
        logic [3:0] chan;
        logic [7:0] note;
        logic       last;
    } t_voice_event;

    // DUT signals
    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic       i_action    = 1'b0;
    logic [7:0] i_data_byte = 8'd0;
    logic       i_ready     = 1'b0;
    logic       o_ready;
    logic       o_valid;
    logic [1:0] o_slot;
    logic [1:0] o_command;
    logic [3:0] o_midi_channel;
    logic [7:0] o_note;
    logic       o_last;

    // Word stream and expected voice events
    t_midi_word   pending_words[$];
    t_voice_event expected_events[$];
    t_midi_word   next_word;
    t_voice_event want_event;
    int           stim_count   = 0;
    bit           drain_req    = 1'b0;
    logic [7:0]   gen_status   = 8'd0;

    // Parser and voice state of the predictor
    t_parse_state pstate;
    logic [7:0]   run_status;
    logic [3:0]   byte_idx;
    logic [7:0]   msg_bytes  [0:2];
    logic [7:0]   voice_chan [0:mpva_pkg::VOICE_COUNT-1];
    logic [7:0]   voice_note [0:mpva_pkg::VOICE_COUNT-1];
    t_voice_event step_events[0:2];
    int           step_count;

    // Flow control and bookkeeping
    int words_in       = 0;
    int errors         = 0;
    int send_gap       = 0;
    int send_burst     = 0;
    int recv_hold      = 0;
    int recv_burst     = 0;
    int idle_cycles    = 0;
    bit long_hold_done = 1'b0;
    int rnd;

    midi_parser_voice_allocator uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_slot         (o_slot),
        .o_command      (o_command),
        .o_midi_channel (o_midi_channel),
        .o_note         (o_note),
        .o_last         (o_last)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Voice allocation predictor
    // ------------------------------------------------------------------
    task automatic emit_event(input int s, input logic [1:0] cmd, input logic [3:0] ch,
                              input logic [7:0] nt);
        t_voice_event ev;
        ev.slot    = s[1:0];
        ev.command = cmd;
        ev.chan    = ch;
        ev.note    = nt;
        ev.last    = 1'b0;
        step_events[step_count] = ev;
        step_count++;
    endtask

    task automatic release_voice(input int s);
        voice_chan[s] = FREE_CHAN;
        voice_note[s] = mpva_pkg::NOTE_NONE;
        emit_event(s, mpva_pkg::CMD_OFF, 4'd0, 8'd0);
    endtask

    task automatic silence_voices();
        int i;
        for (i = 0; i < mpva_pkg::VOICE_COUNT; i++) release_voice(i);
    endtask

    task automatic decode_message();
        logic [3:0] ev;
        logic [3:0] ch;
        logic [7:0] nt;
        logic [7:0] vel;
        logic [7:0] want_ch;
        logic [7:0] want_note;
        int         hit;
        int         i;
        ev  = msg_bytes[0][7:4];
        ch  = msg_bytes[0][3:0];
        nt  = msg_bytes[1];
        vel = msg_bytes[2];
        hit = -1;
        if (ev == mpva_pkg::EV_CTRL) begin
            if (nt == mpva_pkg::CC_ALL_SOUND_OFF ||
                (nt >= mpva_pkg::CC_MODE_LO && nt <= mpva_pkg::CC_MODE_HI))
                silence_voices();
        end else if (ev == mpva_pkg::EV_NOTE_OFF || ev == mpva_pkg::EV_NOTE_ON ||
                     ev == mpva_pkg::EV_KEY_PRES) begin
            // zero velocity turns note-on and key pressure into note-off
            if (ev != mpva_pkg::EV_NOTE_OFF && vel == 8'd0) ev = mpva_pkg::EV_NOTE_OFF;
            want_ch   = (ev == mpva_pkg::EV_NOTE_ON) ? FREE_CHAN : {4'd0, ch};
            want_note = (ev == mpva_pkg::EV_NOTE_ON) ? mpva_pkg::NOTE_NONE : nt;
            // scan down so the lowest matching slot wins
            for (i = mpva_pkg::VOICE_COUNT - 1; i >= 0; i--)
                if (voice_chan[i] == want_ch && voice_note[i] == want_note) hit = i;
            if (hit >= 0) begin
                if (ev == mpva_pkg::EV_NOTE_OFF || nt == mpva_pkg::NOTE_NONE) begin
                    release_voice(hit);
                end else if (ev == mpva_pkg::EV_KEY_PRES) begin
                    emit_event(hit, mpva_pkg::CMD_VOL, 4'd0, 8'd0);
                end else begin
                    voice_chan[hit] = {4'd0, ch};
                    voice_note[hit] = nt;
                    emit_event(hit, mpva_pkg::CMD_ON, ch, nt);
                end
            end
        end
    endtask

    task automatic keep_byte(input logic [7:0] b);
        if (byte_idx < mpva_pkg::MSG_KEEP) msg_bytes[byte_idx[1:0]] = b;
        if (byte_idx != mpva_pkg::IDX_MAX) byte_idx++;
    endtask

    task automatic frame_byte(input logic [7:0] b);
        case (pstate)
            PS_IDLE: begin
                if (b[7:6] == 2'b10 || b[7:4] == mpva_pkg::EV_BEND ||
                    b == mpva_pkg::SYS_SONG_POS)
                    pstate = PS_TWO_DATA;
                else if (b[7:4] == mpva_pkg::EV_PROG || b[7:4] == mpva_pkg::EV_CH_PRES ||
                         b == mpva_pkg::SYS_TIME_CODE || b == mpva_pkg::SYS_SONG_SEL)
                    pstate = PS_LAST_DATA;
                else if (b == mpva_pkg::SYS_EX_START)
                    pstate = PS_SYSEX;
                else
                    pstate = PS_IDLE;
            end
            PS_TWO_DATA: pstate = PS_LAST_DATA;
            PS_SYSEX: begin
                if (b == mpva_pkg::SYS_EX_END) begin
                    decode_message();
                    pstate = PS_IDLE;
                end
            end
            default: begin
                decode_message();
                pstate = PS_IDLE;
            end
        endcase
    endtask

    task automatic predict_voices(input logic act, input logic [7:0] b);
        int i;
        step_count = 0;
        if (act == mpva_pkg::ACT_PANIC) begin
            pstate     = PS_IDLE;
            run_status = 8'd0;
            silence_voices();
        end else if (b[7:3] != mpva_pkg::REALTIME_TOP) begin
            if (pstate == PS_IDLE) begin
                byte_idx = 4'd0;
                if (run_status == 8'd0 || b[7]) begin
                    run_status = b;
                end else begin
                    keep_byte(run_status);
                    frame_byte(run_status);
                end
            end
            keep_byte(b);
            frame_byte(b);
        end
        if (step_count > 0) step_events[step_count - 1].last = 1'b1;
        for (i = 0; i < step_count; i++) expected_events.push_back(step_events[i]);
    endtask

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    task automatic add_word(input logic act, input logic [7:0] b);
        t_midi_word w;
        w.action         = act;
        w.data           = b;
        w.hold_for_drain = drain_req;
        drain_req        = 1'b0;
        pending_words.push_back(w);
        stim_count++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        add_word(mpva_pkg::ACT_BYTE, b);
    endtask

    // sometimes slip a real-time byte in ahead
    task automatic send_byte_rt(input logic [7:0] b);
        if ($urandom_range(0, 9) == 0)
            add_word(mpva_pkg::ACT_BYTE, 8'(RT_CLOCK + $urandom_range(0, 7)));
        add_word(mpva_pkg::ACT_BYTE, b);
    endtask

    function automatic logic [3:0] pick_chan();
        if ($urandom_range(0, 99) < 80) return 4'($urandom_range(0, 1));
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [7:0] pick_note();
        rnd = $urandom_range(0, 99);
        if (rnd < 75) return 8'($urandom_range(60, 63));
        if (rnd < 83) return mpva_pkg::NOTE_NONE;
        if (rnd < 90) return 8'($urandom_range(129, 247));
        return 8'($urandom_range(0, 127));
    endfunction

    function automatic logic [7:0] pick_vel();
        rnd = $urandom_range(0, 99);
        if (rnd < 20) return 8'd0;
        if (rnd < 92) return 8'($urandom_range(1, 127));
        return 8'($urandom_range(128, 247));
    endfunction

    function automatic logic [7:0] pick_ctrl();
        rnd = $urandom_range(0, 99);
        if (rnd < 45) return ($urandom_range(0, 6) == 0)
                             ? mpva_pkg::CC_ALL_SOUND_OFF
                             : 8'(mpva_pkg::CC_MODE_LO + $urandom_range(0, 5));
        if (rnd < 55) return mpva_pkg::CC_ALL_SOUND_OFF + 8'd1;
        if (rnd < 93) return 8'($urandom_range(0, 127));
        return 8'($urandom_range(128, 247));
    endfunction

    function automatic int gap_len();
        rnd = $urandom_range(0, 99);
        if (rnd < 75) return $urandom_range(1, 3);
        if (rnd < 96) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Send a channel voice message, dropping the status under running status
    task automatic channel_msg(input logic [3:0] ev, input int ndata, input logic [7:0] d1,
                               input logic [7:0] d2);
        logic [7:0] st;
        st = {ev, pick_chan()};
        if (st != gen_status || $urandom_range(0, 3) == 0) send_byte_rt(st);
        gen_status = st;
        send_byte_rt(d1);
        if (ndata == 2) send_byte_rt(d2);
    endtask

    task automatic random_message();
        int kind;
        int len;
        int k;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            channel_msg(mpva_pkg::EV_NOTE_ON, 2, pick_note(), pick_vel());
        end else if (kind < 55) begin
            channel_msg(mpva_pkg::EV_NOTE_OFF, 2, pick_note(), 8'($urandom_range(0, 127)));
        end else if (kind < 65) begin
            channel_msg(mpva_pkg::EV_KEY_PRES, 2, pick_note(), pick_vel());
        end else if (kind < 73) begin
            channel_msg(mpva_pkg::EV_CTRL, 2, pick_ctrl(), 8'($urandom_range(0, 127)));
        end else if (kind < 77) begin
            channel_msg($urandom_range(0, 1) ? mpva_pkg::EV_PROG : mpva_pkg::EV_CH_PRES, 1,
                        8'($urandom_range(0, 127)), 8'd0);
        end else if (kind < 80) begin
            channel_msg(mpva_pkg::EV_BEND, 2, 8'($urandom_range(0, 127)),
                        8'($urandom_range(0, 127)));
        end else if (kind < 84) begin
            // system exclusive, now and then long enough to saturate the index
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(14, 18) : $urandom_range(0, 4);
            send_byte_rt(mpva_pkg::SYS_EX_START);
            for (k = 0; k < len; k++) send_byte_rt(8'($urandom_range(0, 127)));
            send_byte_rt(mpva_pkg::SYS_EX_END);
            gen_status = 8'd0;
        end else if (kind < 87) begin
            rnd = $urandom_range(0, 3);
            if (rnd == 0) begin
                send_byte_rt(mpva_pkg::SYS_SONG_POS);
                send_byte_rt(8'($urandom_range(0, 127)));
                send_byte_rt(8'($urandom_range(0, 127)));
            end else if (rnd == 1) begin
                send_byte_rt($urandom_range(0, 1) ? mpva_pkg::SYS_TIME_CODE
                                                  : mpva_pkg::SYS_SONG_SEL);
                send_byte_rt(8'($urandom_range(0, 127)));
            end else begin
                send_byte_rt(8'(SYS_TUNE_REQ - $urandom_range(0, 2)));
            end
            gen_status = 8'd0;
        end else if (kind < 91) begin
            add_word(mpva_pkg::ACT_BYTE, 8'(RT_CLOCK + $urandom_range(0, 7)));
        end else if (kind < 94) begin
            add_word(mpva_pkg::ACT_PANIC, 8'($urandom_range(0, 255)));
            gen_status = 8'd0;
        end else begin
            // broken sequence: a few raw bytes
            len = $urandom_range(1, 3);
            for (k = 0; k < len; k++) send_byte(8'($urandom_range(0, 255)));
            gen_status = 8'd0;
        end
    endtask

    // ------------------------------------------------------------------
    // Driver: offer pending words, predict on acceptance
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                predict_voices(i_action, i_data_byte);
                words_in++;
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_valid <= 1'b0;
                end else if (pending_words.size() != 0 &&
                             !(pending_words[0].hold_for_drain &&
                               expected_events.size() != 0)) begin
                    next_word = pending_words.pop_front();
                    i_valid     <= 1'b1;
                    i_action    <= next_word.action;
                    i_data_byte <= next_word.data;
                    // pick the gap before the following word
                    if (send_burst > 0) begin
                        send_burst--;
                        send_gap = 0;
                    end else begin
                        rnd = $urandom_range(0, 99);
                        if (rnd < 5) begin
                            send_burst = $urandom_range(10, 40);
                            send_gap   = 0;
                        end else if (rnd < 50) begin
                            send_gap = 0;
                        end else begin
                            send_gap = gap_len();
                        end
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: check results, throttle the result side
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int exp_val, input int act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val,
                     act_val);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                if (expected_events.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual slot %0d cmd %0d",
                             $time, o_slot, o_command);
                    errors++;
                end else begin
                    want_event = expected_events.pop_front();
                    check_field("slot", int'(want_event.slot), int'(o_slot));
                    check_field("command", int'(want_event.command), int'(o_command));
                    check_field("midi_channel", int'(want_event.chan),
                                int'(o_midi_channel));
                    check_field("note", int'(want_event.note), int'(o_note));
                    check_field("last", int'(want_event.last), int'(o_last));
                end
            end
            // hold off, once for a long stretch so the block backs up
            if (recv_hold > 0) begin
                recv_hold--;
                i_ready <= 1'b0;
            end else if (!long_hold_done && words_in >= HOLD_AT_WORD) begin
                long_hold_done = 1'b1;
                recv_hold      = LONG_HOLD - 1;
                i_ready <= 1'b0;
            end else if (recv_burst > 0) begin
                recv_burst--;
                i_ready <= 1'b1;
            end else begin
                rnd = $urandom_range(0, 99);
                if (rnd < 5) begin
                    recv_burst = $urandom_range(10, 40);
                    i_ready <= 1'b1;
                end else if (rnd < 55) begin
                    i_ready <= 1'b1;
                end else begin
                    recv_hold = gap_len() - 1;
                    i_ready <= 1'b0;
                end
            end
        end
    end

    // Watchdog: stop when nothing moves for too long
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        int i;
        int rand_base;
        int next_drain;

        // predictor starts from reset
        pstate     = PS_IDLE;
        run_status = 8'd0;
        byte_idx   = 4'd0;
        for (i = 0; i < 3; i++) msg_bytes[i] = 8'd0;
        for (i = 0; i < mpva_pkg::VOICE_COUNT; i++) begin
            voice_chan[i] = FREE_CHAN;
            voice_note[i] = mpva_pkg::NOTE_NONE;
        end

        // fill all three voices, real-time byte in between, then no free slot
        send_byte(8'h90); send_byte(8'd60); send_byte(8'd100);
        send_byte(8'd62); send_byte(8'd100);
        send_byte(RT_CLOCK); send_byte(8'd64); send_byte(8'd127);
        send_byte(8'd65); send_byte(8'd1);
        // key pressure: full volume, then zero velocity frees
        send_byte(8'hA0); send_byte(8'd60); send_byte(8'd127);
        send_byte(8'd62); send_byte(8'd0);
        // note-on with zero velocity, note-off, note-off without a match
        send_byte(8'h90); send_byte(8'd64); send_byte(8'd0);
        send_byte(8'h80); send_byte(8'd60); send_byte(8'd64);
        send_byte(8'd60); send_byte(8'd64);
        // status bytes taken as data: note 128 stays free, top note on channel 15
        send_byte(8'h9F); send_byte(8'h80); send_byte(8'h7F);
        send_byte(8'h9F); send_byte(8'hF7); send_byte(8'h01);
        // controllers that silence all and one that does not
        send_byte(8'hB3); send_byte(mpva_pkg::CC_ALL_SOUND_OFF); send_byte(8'd0);
        send_byte(mpva_pkg::CC_ALL_SOUND_OFF + 8'd1); send_byte(8'd0);
        send_byte(mpva_pkg::CC_MODE_HI); send_byte(8'd0);
        // messages that decode to nothing
        send_byte(8'hC5); send_byte(8'd7);
        send_byte(8'hE0); send_byte(8'd0); send_byte(8'd127);
        send_byte(mpva_pkg::SYS_EX_START); send_byte(8'h7E); send_byte(mpva_pkg::SYS_EX_END);
        // panic, then data with no running status, then real-time top
        add_word(mpva_pkg::ACT_PANIC, 8'hFF);
        send_byte(8'h40); send_byte(8'h00); send_byte(8'hFF);

        // random part, with periodic pauses until the block drains
        rand_base  = stim_count;
        next_drain = 0;
        while (stim_count - rand_base < RANDOM_ITEMS) begin
            if (stim_count - rand_base >= next_drain) begin
                drain_req  = 1'b1;
                next_drain = next_drain + DRAIN_EVERY;
            end
            random_message();
        end

        // release reset
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // wait for every word to go in and every result to come out
        while (pending_words.size() != 0 || i_valid) @(posedge i_clk);
        while (expected_events.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/mpva_pkg.sv
rtl/mpva_parser.sv
rtl/mpva_voices.sv
rtl/mpva_out_buf.sv
rtl/midi_parser_voice_allocator.sv
verif/tb_midi_parser_voice_allocator.sv
